FILE: rtl/core/lfb64_pkg.sv
// package for the lsb-first base64 codec: result types and alphabet functions
// used by lfb64_step and lsb_first_base64_codec; no dependencies
`default_nettype none

package lfb64_pkg;

    // result queue depth, enough for two items of two results each
    localparam int RQ_DEPTH = 4;

    typedef enum logic [1:0] {
        K_DATA    = 2'd0,
        K_INVALID = 2'd1,
        K_END     = 2'd2
    } t_kind;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef struct packed {
        logic [7:0] value;
        t_kind      kind;
        logic       run_end;
        logic       string_end;
    } t_result;

    typedef struct packed {
        logic [1:0]  n;
        t_result     res0;
        t_result     res1;
        logic [12:0] acc;
        logic [3:0]  cnt;
    } t_step_out;

    // 6-bit group to alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] s;
        s = {2'b00, six};
        if (six < 6'd26) begin
            return 8'h41 + s;
        end else if (six < 6'd52) begin
            return 8'h61 + (s - 8'd26);
        end else if (six < 6'd62) begin
            return 8'h30 + (s - 8'd52);
        end else if (six == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // character to {invalid, 6-bit group}
    function automatic logic [6:0] b64_six(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
            return {1'b0, d[5:0]};
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61 + 8'd26;
            return {1'b0, d[5:0]};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30 + 8'd52;
            return {1'b0, d[5:0]};
        end else if (ch == 8'h2B) begin
            return {1'b0, 6'd62};
        end else if (ch == 8'h2F) begin
            return {1'b0, 6'd63};
        end else begin
            return {1'b1, 6'd0};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lfb64_step.sv
// one codec step: results and next accumulator state for one item
// depends on lfb64_pkg
`default_nettype none

module lfb64_step (
    input  wire logic                 i_dir,
    input  wire logic [12:0]          i_acc,
    input  wire logic [3:0]           i_cnt,
    input  wire logic [7:0]           i_symbol,
    input  wire logic                 i_last,
    output lfb64_pkg::t_step_out      o_step
);
    import lfb64_pkg::*;

    logic [15:0] enc_wide16;
    logic [12:0] enc_wide;
    logic [4:0]  enc_c8;
    logic        enc_two;
    logic [4:0]  enc_rem;
    logic [12:0] enc_acc;
    logic        enc_tail;
    logic [6:0]  dec_map;
    logic [15:0] dec_wide16;
    logic [12:0] dec_wide;
    logic [4:0]  dec_c6;
    logic        dec_emit;
    t_step_out   st;

    // encode: byte goes above held bits, one or two groups leave
    always_comb begin
        enc_wide16 = {8'd0, i_symbol} << i_cnt[2:0];
        enc_wide   = i_acc | enc_wide16[12:0];
        enc_c8     = {1'b0, i_cnt} + 5'd8;
        enc_two    = (enc_c8 >= 5'd12);
        enc_rem    = enc_c8 - 5'd6 - (enc_two ? 5'd6 : 5'd0);
        enc_acc    = enc_two ? (enc_wide >> 12) : (enc_wide >> 6);
        enc_tail   = i_last && (enc_rem != 5'd0) && !enc_two;
    end

    // decode: character maps to six bits above held bits
    always_comb begin
        dec_map    = b64_six(i_symbol);
        dec_wide16 = {10'd0, dec_map[5:0]} << i_cnt[2:0];
        dec_wide   = i_acc | dec_wide16[12:0];
        dec_c6     = {1'b0, i_cnt} + 5'd6;
        dec_emit   = (dec_c6 >= 5'd8);
    end

    // result selection and end flags
    always_comb begin
        st = '0;
        st.res0.kind = K_DATA;
        st.res1.kind = K_DATA;
        if (i_dir == DIR_ENCODE) begin
            st.res0.value = b64_char(enc_wide[5:0]);
            st.res1.value = enc_two ? b64_char(enc_wide[11:6]) : b64_char(enc_acc[5:0]);
            st.n   = (enc_two || enc_tail) ? 2'd2 : 2'd1;
            st.acc = enc_acc;
            st.cnt = enc_rem[3:0];
        end else if (dec_map[6]) begin
            st.n         = 2'd1;
            st.res0.kind = K_INVALID;
        end else if (dec_emit) begin
            st.n          = 2'd1;
            st.res0.value = dec_wide[7:0];
            st.acc        = dec_wide >> 8;
            st.cnt        = dec_c6[3:0] - 4'd8;
        end else begin
            st.n   = i_last ? 2'd1 : 2'd0;
            st.res0.kind = i_last ? K_END : K_DATA;
            st.acc = dec_wide;
            st.cnt = dec_c6[3:0];
        end
        if (st.n == 2'd1) begin
            st.res0.run_end    = 1'b1;
            st.res0.string_end = i_last;
        end
        if (st.n == 2'd2) begin
            st.res1.run_end    = 1'b1;
            st.res1.string_end = i_last;
        end
        if (i_last) begin
            st.acc = '0;
            st.cnt = '0;
        end
        o_step = st;
    end

endmodule

`default_nettype wire

FILE: rtl/core/lsb_first_base64_codec.sv
// lsb-first base64 codec, top level: input register, step logic, result queue
// depends on lfb64_pkg and lfb64_step
//
// Streaming base64 codec with bits packed least significant first. An item is
// taken into an input register in any cycle that o_in_stall is low; once the
// result queue has room for two results, the step logic writes its zero to two
// results into a four-entry result queue, one of which is shown per cycle while
// i_out_stall is low. While encoding, the input rate is set by the single result
// per cycle of the output queue: three bytes give four characters, and a byte
// that ends its string with bits left over gives two characters, so the input is
// stalled while the queue lacks room. Decoding gives at most one result per item
// and sustains one item per cycle while i_out_stall is low. The direction
// register is written through the config channel; the user must write it only
// while the block is idle, which the block itself does not enforce. A write
// clears the bit accumulator. o_cfg_ready is always high.
`default_nettype none

module lsb_first_base64_codec (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_value,
    output logic [1:0]      o_kind,
    output logic            o_run_end,
    output logic            o_string_end
);
    import lfb64_pkg::*;

    localparam int PW = $clog2(RQ_DEPTH);

    logic          r_dir;
    logic [12:0]   r_acc;
    logic [3:0]    r_cnt;
    logic          r_in_vld;
    logic [7:0]    r_sym;
    logic          r_last;
    t_result       r_rq [RQ_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_fill;
    logic [PW:0]   n_fill;
    t_step_out     step;
    t_result       head;
    logic          advance;
    logic          accept;
    logic          pop;
    logic          cfg_wr;

    // step logic on the registered item
    lfb64_step u_step (
        .i_dir    (r_dir),
        .i_acc    (r_acc),
        .i_cnt    (r_cnt),
        .i_symbol (r_sym),
        .i_last   (r_last),
        .o_step   (step)
    );

    // handshakes
    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_vld && (r_fill <= (PW+1)'(RQ_DEPTH - 2));
    assign o_in_stall  = r_in_vld && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fill != '0);
    assign pop         = o_out_valid && !i_out_stall;

    // direction register and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (cfg_wr) begin
            r_dir <= i_cfg_data;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (advance) begin
            r_acc <= step.acc;
            r_cnt <= step.cnt;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (advance && step.n != 2'd0) begin
            r_rq[r_wr] <= step.res0;
        end
        if (advance && step.n == 2'd2) begin
            r_rq[r_wr + PW'(1)] <= step.res1;
        end
    end

    // result queue pointers
    always_comb begin
        n_fill = r_fill;
        if (advance) begin
            n_fill = n_fill + (PW+1)'(step.n);
        end
        if (pop) begin
            n_fill = n_fill - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (advance) begin
                r_wr <= r_wr + PW'(step.n);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
        end
    end

    // head of queue drives the result ports
    assign head         = r_rq[r_rd];
    assign o_value      = head.value;
    assign o_kind       = head.kind;
    assign o_run_end    = head.run_end;
    assign o_string_end = head.string_end;

endmodule

`default_nettype wire

FILE: rtl/core/lfb64_checker.sv
// port-level checks for lsb_first_base64_codec, attached by bind
// depends on lfb64_pkg
`default_nettype none

module lfb64_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_value,
    input wire logic [1:0] o_kind,
    input wire logic       o_run_end,
    input wire logic       o_string_end
);
    import lfb64_pkg::*;

    // nothing shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // error and end marker results carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != K_DATA) |-> (o_value == 8'd0))
        else $error("non-data result with nonzero value");

    // end of string only on the last result of an item
    a_string_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_end |-> o_run_end)
        else $error("string end without run end");

    // error and end marker are always single results
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == K_INVALID || o_kind == K_END) |-> o_run_end)
        else $error("error or marker result not closing its item");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_kind) && $stable(o_run_end) && $stable(o_string_end))
        else $error("stalled result changed");

endmodule

bind lsb_first_base64_codec lfb64_checker u_lfb64_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_value      (o_value),
    .o_kind       (o_kind),
    .o_run_end    (o_run_end),
    .o_string_end (o_string_end)
);

`default_nettype wire
